@@ rtl/inverter_response_deframer_unit_defines.svh @@
// assertion macros for the inverter response deframer
// used by the controller and datapath modules, no other dependencies
`ifndef INVERTER_RESPONSE_DEFRAMER_UNIT_DEFINES_SVH
`define INVERTER_RESPONSE_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define IRD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define IRD_ASSERT_NEVER(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define IRD_ASSERT(name, clk, rst_n, prop, msg)
`define IRD_ASSERT_NEVER(name, clk, rst_n, prop, msg)
`endif

`endif

@@ rtl/ird_pkg.sv @@
// shared constants and types for the inverter response deframer
// no dependencies
package ird_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 17;

  localparam logic [7:0] HDR_SHORT     = 8'hA6;
  localparam logic [7:0] HDR_LONG      = 8'h5A;
  localparam logic [4:0] LEN_SHORT     = 5'd15;
  localparam logic [4:0] LEN_LONG      = 5'd17;
  localparam logic [4:0] FPOS_SHORT    = 5'd3;
  localparam logic [4:0] FPOS_LONG     = 5'd2;
  localparam logic [7:0] CHECK_BASE    = 8'hFF;
  localparam logic [7:0] TIMEOUT_RESET = 8'd50;
  localparam logic [7:0] GAP_MAX       = 8'hFF;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic RK_BYTE = 1'b0;
  localparam logic RK_ERR  = 1'b1;

  typedef struct packed {
    logic take;
    logic err_load;
    logic emit_load;
  } ird_cmd_t;

  typedef struct packed {
    logic good_end;
    logic bad_end;
    logic emit_last;
    logic out_free;
  } ird_sts_t;

endpackage

@@ rtl/ird_ctrl.sv @@
// controller state machine: input handshake and frame emission sequencing
// depends on ird_pkg and the assertion macro header
`include "inverter_response_deframer_unit_defines.svh"

module ird_ctrl import ird_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ird_sts_t sts_i,
  output ird_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o           = '0;
    state_d         = state_q;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = sts_i.out_free;
        cmd_o.take     = in_valid_i && sts_i.out_free;
        cmd_o.err_load = cmd_o.take && sts_i.bad_end;
        if (cmd_o.take && sts_i.good_end) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_load = sts_i.out_free;
        if (sts_i.out_free && sts_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `IRD_ASSERT_NEVER(a_take_during_emit, clk_i, rst_ni, cmd_o.take && cmd_o.emit_load, "input taken while emitting")
  `IRD_ASSERT(a_emit_entry, clk_i, rst_ni, cmd_o.take && sts_i.good_end |=> state_q == ST_EMIT, "good frame did not start emission")
  `IRD_ASSERT_NEVER(a_both_ends, clk_i, rst_ni, sts_i.good_end && sts_i.bad_end, "frame both good and bad")

endmodule

@@ rtl/ird_datapath.sv @@
// datapath: frame store, fill and gap counters, checksum and output register
// depends on ird_pkg and the assertion macro header
`include "inverter_response_deframer_unit_defines.svh"

module ird_datapath import ird_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_cmd_i,
  input  logic [7:0] in_byte_i,
  input  ird_cmd_t   cmd_i,
  output ird_sts_t   sts_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic       out_kind_o,
  output logic       out_type_o,
  output logic [3:0] out_func_o,
  output logic [4:0] out_idx_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  localparam int unsigned IdxW = $clog2(MaxFrameBytes);

  logic [7:0]      store_q [MaxFrameBytes];
  logic [IdxW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] emit_idx_q, emit_idx_d;
  logic [7:0]      gap_q, gap_d, gap_inc;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      timeout_q;
  logic            long_q, long_d;
  logic [3:0]      func_q;
  logic            func_we;
  logic            store_we;
  logic [IdxW-1:0] store_wa;
  logic [IdxW-1:0] len, last_pos, fpos;
  logic            is_byte, is_end, check_ok;

  logic       out_valid_q;
  logic       out_kind_q, out_type_q, out_last_q;
  logic [3:0] out_func_q;
  logic [4:0] out_idx_q;
  logic [7:0] out_byte_q;

  assign len      = long_q ? IdxW'(LEN_LONG) : IdxW'(LEN_SHORT);
  assign last_pos = len - IdxW'(1);
  assign fpos     = long_q ? IdxW'(FPOS_LONG) : IdxW'(FPOS_SHORT);
  assign is_byte  = (in_cmd_i == CMD_BYTE);
  assign is_end   = is_byte && (fill_q != '0) && (fill_q == last_pos);
  assign check_ok = ((CHECK_BASE - sum_q) == in_byte_i);
  assign gap_inc  = (gap_q == GAP_MAX) ? gap_q : gap_q + 8'd1;

  assign sts_o.good_end  = is_end && check_ok;
  assign sts_o.bad_end   = is_end && !check_ok;
  assign sts_o.emit_last = (emit_idx_q == last_pos);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    fill_d   = fill_q;
    gap_d    = gap_q;
    sum_d    = sum_q;
    long_d   = long_q;
    store_we = 1'b0;
    store_wa = fill_q;
    func_we  = 1'b0;
    if (cmd_i.take) begin
      if (!is_byte) begin
        if (gap_inc > timeout_q) begin
          fill_d = '0;
          sum_d  = '0;
          gap_d  = '0;
        end else begin
          gap_d = gap_inc;
        end
      end else begin
        gap_d = '0;
        if (fill_q == '0) begin
          if (in_byte_i == HDR_SHORT || in_byte_i == HDR_LONG) begin
            store_we = 1'b1;
            long_d   = (in_byte_i == HDR_LONG);
            sum_d    = '0;
            fill_d   = IdxW'(1);
          end
        end else if (fill_q >= len) begin
          fill_d = '0;
          sum_d  = '0;
        end else begin
          store_we = 1'b1;
          if (fill_q < last_pos) begin
            sum_d   = sum_q + in_byte_i;
            fill_d  = fill_q + IdxW'(1);
            func_we = (fill_q == fpos);
          end else begin
            fill_d = '0;
            sum_d  = '0;
          end
        end
      end
    end
  end

  always_comb begin
    emit_idx_d = emit_idx_q;
    if (cmd_i.take && sts_o.good_end) begin
      emit_idx_d = '0;
    end else if (cmd_i.emit_load) begin
      emit_idx_d = emit_idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[store_wa] <= in_byte_i;
    end
    if (func_we) begin
      func_q <= in_byte_i[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      gap_q      <= '0;
      sum_q      <= '0;
      long_q     <= 1'b0;
      emit_idx_q <= '0;
      timeout_q  <= TIMEOUT_RESET;
    end else begin
      fill_q     <= fill_d;
      gap_q      <= gap_d;
      sum_q      <= sum_d;
      long_q     <= long_d;
      emit_idx_q <= emit_idx_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.err_load || cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_load) begin
      out_kind_q <= RK_ERR;
      out_type_q <= long_q;
      out_func_q <= func_q;
      out_idx_q  <= 5'(last_pos);
      out_byte_q <= in_byte_i;
      out_last_q <= 1'b1;
    end else if (cmd_i.emit_load) begin
      out_kind_q <= RK_BYTE;
      out_type_q <= long_q;
      out_func_q <= func_q;
      out_idx_q  <= 5'(emit_idx_q);
      out_byte_q <= store_q[emit_idx_q];
      out_last_q <= sts_o.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_type_o  = out_type_q;
  assign out_func_o  = out_func_q;
  assign out_idx_o   = out_idx_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  `IRD_ASSERT(a_load_when_free, clk_i, rst_ni, cmd_i.err_load || cmd_i.emit_load |-> sts_o.out_free, "output register overwritten")
  `IRD_ASSERT(a_fill_range, clk_i, rst_ni, fill_q < IdxW'(LEN_LONG), "fill position out of range")
  `IRD_ASSERT(a_emit_range, clk_i, rst_ni, cmd_i.emit_load |-> emit_idx_q <= last_pos, "emit index past frame end")

endmodule

@@ rtl/inverter_response_deframer_unit.sv @@
// inverter response deframer, top level
// timing: an error result is valid the cycle after its check byte is taken, the first byte
// of a good frame after ST_EMIT; then one byte per cycle while ready, 15 or 17 bytes in all
// input is held off while a frame streams or a result waits; other items do not stall it
// reset is asynchronous active low: buffer empty, counters zero, gap timeout 50 ticks
// depends on ird_pkg, ird_ctrl and ird_datapath
module inverter_response_deframer_unit import ird_pkg::*; #(
  parameter int unsigned MaxFrameBytes = MAX_FRAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] function_code, [8:4] byte_index,
                                      // [16:9] frame_byte, [23:17] zero
  output logic [1:0]  m_axis_tuser,   // [0] result_kind, [1] frame_type
  output logic        m_axis_tlast    // last_of_frame
);

  ird_cmd_t   cmd;
  ird_sts_t   sts;
  logic       out_kind, out_type;
  logic [3:0] out_func;
  logic [4:0] out_idx;
  logic [7:0] out_byte;

  ird_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ird_datapath #(
    .MaxFrameBytes (MaxFrameBytes)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (out_kind),
    .out_type_o  (out_type),
    .out_func_o  (out_func),
    .out_idx_o   (out_idx),
    .out_byte_o  (out_byte),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_byte, out_idx, out_func};
  assign m_axis_tuser = {out_type, out_kind};

endmodule
